/* design/packet_sequence_rate_monitor_macros.svh */
// assertion macros for the packet sequence and rate monitor
// no dependencies; included by packet_sequence_rate_monitor.sv, the only file that carries assertions
`ifndef PACKET_SEQUENCE_RATE_MONITOR_MACROS_SVH
`define PACKET_SEQUENCE_RATE_MONITOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define PSRM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psrm assertion failed");

// next-cycle implication, checked out of reset
`define PSRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psrm assertion failed");

`endif

/* design/psrm_pkg.sv */
// shared types and constants for the packet sequence and rate monitor
// no dependencies
package psrm_pkg;

  localparam int unsigned WINDOW     = 20;
  localparam int unsigned IDX_W      = $clog2(WINDOW);
  localparam int unsigned FILL_W     = $clog2(WINDOW + 1);
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned NUM_W      = 23;
  localparam int unsigned DCNT_W     = $clog2(NUM_W + 1);
  localparam int unsigned RATE_SCALE = 256000;

  typedef struct packed {
    logic              packet_valid;
    logic [SEQ_W-1:0]  seq_number;
    logic [TIME_W-1:0] arrival_ms;
  } in_item_t;

  typedef struct packed {
    logic              gap_flag;
    logic [SEQ_W-1:0]  gap_size;
    logic [SEQ_W-1:0]  gap_expected_seq;
    logic [SEQ_W-1:0]  rx_seq_num;
    logic [NUM_W-1:0]  rate_q8;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* design/psrm_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module psrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/psrm_div.sv */
// restoring divider, one quotient bit per cycle
// depends on psrm_pkg
module psrm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [psrm_pkg::NUM_W-1:0]    dividend,
  input  logic [psrm_pkg::TIME_W-1:0]   divisor,
  output logic [psrm_pkg::NUM_W-1:0]    quotient,
  output psrm_pkg::div_sts_t            sts
);

  logic [psrm_pkg::NUM_W-1:0]  quo_r, quo_nxt;
  logic [psrm_pkg::TIME_W-1:0] rem_r, rem_nxt;
  logic [psrm_pkg::TIME_W-1:0] dsr_r, dsr_nxt;
  logic [psrm_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [psrm_pkg::TIME_W:0]   rem_sh;
  logic [psrm_pkg::TIME_W:0]   rem_sub;
  logic                        q_bit;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[psrm_pkg::NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    q_bit   = (rem_sh >= {1'b0, dsr_r});
  end

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = psrm_pkg::DCNT_W'(psrm_pkg::NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[psrm_pkg::NUM_W-2:0], q_bit};
      rem_nxt = q_bit ? rem_sub[psrm_pkg::TIME_W-1:0] : rem_sh[psrm_pkg::TIME_W-1:0];
      cnt_nxt = cnt_r - psrm_pkg::DCNT_W'(1);
      if (cnt_r == psrm_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* design/packet_sequence_rate_monitor.sv */
// Packet sequence and rate monitor. One item per packet arrival; an item with
// packet_valid low is accepted in the idle state and gives no result. A valid
// item gives exactly one result: gap flag, latched gap size and expected
// number, its own sequence number, and the arrival rate over the last 20
// arrivals in 1/256 Hz. A valid item occupies the block while it is taken and
// its time stored, the ring is read, the divider is set up, the bit-serial
// divider runs, the quotient is picked up and the result is handed to the
// output register; that handoff waits while the register still holds a result
// not yet taken. When no division is needed (fewer than two samples or zero
// time span) the divider steps are skipped. The output register lets the next
// item be taken while a result still waits on out_ready.
// depends on psrm_pkg, psrm_ram, psrm_div and packet_sequence_rate_monitor_macros.svh
`include "packet_sequence_rate_monitor_macros.svh"

module packet_sequence_rate_monitor (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  psrm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output psrm_pkg::out_item_t  out_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
  localparam logic [2:0] S_READ = 3'd1;  // read oldest ring time
  localparam logic [2:0] S_CALC = 3'd2;  // span and divider setup
  localparam logic [2:0] S_DIV  = 3'd3;  // divider running
  localparam logic [2:0] S_FIN  = 3'd4;  // load output register

  logic [2:0] state_r, state_nxt;

  // sequence tracking
  logic [psrm_pkg::SEQ_W-1:0]  next_exp_r, next_exp_nxt;
  logic                        seq_seen_r, seq_seen_nxt;
  logic [psrm_pkg::SEQ_W-1:0]  held_missed_r, held_missed_nxt;
  logic [psrm_pkg::SEQ_W-1:0]  held_gexp_r, held_gexp_nxt;
  logic [psrm_pkg::NUM_W-1:0]  held_rate_r, held_rate_nxt;
  logic                        gap_r, gap_nxt;
  logic [psrm_pkg::SEQ_W-1:0]  rcv_seq_r, rcv_seq_nxt;

  // time ring bookkeeping
  logic [psrm_pkg::IDX_W-1:0]  head_r, head_nxt;
  logic [psrm_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [psrm_pkg::IDX_W-1:0]  oldest_r, oldest_nxt;
  logic [psrm_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [psrm_pkg::IDX_W:0]    oldest_sum;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  psrm_pkg::out_item_t         out_data_r, out_data_nxt;

  // ring and divider hookup
  logic                        ring_we;
  logic                        ring_re;
  logic [psrm_pkg::TIME_W-1:0] ring_rdata;
  logic [psrm_pkg::TIME_W-1:0] delta;
  logic                        div_start;
  logic [psrm_pkg::NUM_W-1:0]  div_dividend;
  logic [psrm_pkg::NUM_W-1:0]  div_quot;
  psrm_pkg::div_sts_t          div_sts;

  logic in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // time span back to the oldest sample still in the window
  assign delta = now_r - ring_rdata;

  // (fill-1) * 256000, at most 23 bits for any window up to 32
  assign div_dividend = psrm_pkg::NUM_W'(
      32'(fill_r - psrm_pkg::FILL_W'(1)) * psrm_pkg::RATE_SCALE);

  // slot of the sample taken fill-1 items before the newest, after the update
  always_comb begin
    logic [psrm_pkg::IDX_W:0] wsum;
    wsum = {1'b0, head_nxt} + (psrm_pkg::IDX_W + 1)'(psrm_pkg::WINDOW)
         - (psrm_pkg::IDX_W + 1)'(fill_nxt);
    oldest_sum = wsum;
  end

  always_comb begin
    state_nxt       = state_r;
    next_exp_nxt    = next_exp_r;
    seq_seen_nxt    = seq_seen_r;
    held_missed_nxt = held_missed_r;
    held_gexp_nxt   = held_gexp_r;
    held_rate_nxt   = held_rate_r;
    gap_nxt         = gap_r;
    rcv_seq_nxt     = rcv_seq_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    now_nxt         = now_r;
    oldest_nxt      = oldest_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    ring_we         = 1'b0;
    ring_re         = 1'b0;
    div_start       = 1'b0;

    // result taken downstream frees the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // ring pointer update, used by the accept arm below
    if (head_r == psrm_pkg::IDX_W'(psrm_pkg::WINDOW - 1)) begin
      head_nxt = '0;
    end else begin
      head_nxt = head_r + psrm_pkg::IDX_W'(1);
    end
    if (fill_r < psrm_pkg::FILL_W'(psrm_pkg::WINDOW)) begin
      fill_nxt = fill_r + psrm_pkg::FILL_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        // hold pointers unless a valid packet comes in
        if (!(in_acc && in_data.packet_valid)) begin
          head_nxt = head_r;
          fill_nxt = fill_r;
        end else begin
          gap_nxt = 1'b0;
          if (seq_seen_r) begin
            if (in_data.seq_number != next_exp_r) begin
              gap_nxt         = 1'b1;
              held_missed_nxt = in_data.seq_number - next_exp_r;
              held_gexp_nxt   = next_exp_r;
            end
          end
          seq_seen_nxt = 1'b1;
          next_exp_nxt = in_data.seq_number + psrm_pkg::SEQ_W'(1);
          rcv_seq_nxt  = in_data.seq_number;
          now_nxt      = in_data.arrival_ms;
          ring_we      = 1'b1;
          if (oldest_sum >= (psrm_pkg::IDX_W + 1)'(psrm_pkg::WINDOW)) begin
            oldest_nxt = psrm_pkg::IDX_W'(oldest_sum
                       - (psrm_pkg::IDX_W + 1)'(psrm_pkg::WINDOW));
          end else begin
            oldest_nxt = oldest_sum[psrm_pkg::IDX_W-1:0];
          end
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        head_nxt  = head_r;
        fill_nxt  = fill_r;
        ring_re   = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        head_nxt = head_r;
        fill_nxt = fill_r;
        // rate held when fewer than two samples or no elapsed time
        if (fill_r >= psrm_pkg::FILL_W'(2) && delta != '0) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        head_nxt = head_r;
        fill_nxt = fill_r;
        if (div_sts.done) begin
          held_rate_nxt = div_quot;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        head_nxt = head_r;
        fill_nxt = fill_r;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.gap_flag         = gap_r;
          out_data_nxt.gap_size         = held_missed_r;
          out_data_nxt.gap_expected_seq = held_gexp_r;
          out_data_nxt.rx_seq_num       = rcv_seq_r;
          out_data_nxt.rate_q8          = held_rate_r;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        head_nxt  = head_r;
        fill_nxt  = fill_r;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      next_exp_r    <= '0;
      seq_seen_r    <= 1'b0;
      held_missed_r <= '0;
      held_gexp_r   <= '0;
      held_rate_r   <= '0;
      head_r        <= '0;
      fill_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      next_exp_r    <= next_exp_nxt;
      seq_seen_r    <= seq_seen_nxt;
      held_missed_r <= held_missed_nxt;
      held_gexp_r   <= held_gexp_nxt;
      held_rate_r   <= held_rate_nxt;
      head_r        <= head_nxt;
      fill_r        <= fill_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    gap_r      <= gap_nxt;
    rcv_seq_r  <= rcv_seq_nxt;
    now_r      <= now_nxt;
    oldest_r   <= oldest_nxt;
    out_data_r <= out_data_nxt;
  end

  // arrival time ring
  psrm_ram #(
    .WIDTH (psrm_pkg::TIME_W),
    .DEPTH (psrm_pkg::WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (head_r),
    .wdata (in_data.arrival_ms),
    .re    (ring_re),
    .raddr (oldest_r),
    .rdata (ring_rdata)
  );

  // rate divider
  psrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (delta),
    .quotient (div_quot),
    .sts      (div_sts)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // fill count saturates at the window size
  `PSRM_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= psrm_pkg::FILL_W'(psrm_pkg::WINDOW))
  // no item taken while the divider runs
  `PSRM_ASSERT_IMPL(a_busy_no_accept, clk, rst_n, div_sts.busy, !in_ready)
  // divider completion only seen while waiting for it
  `PSRM_ASSERT_IMPL(a_done_in_div, clk, rst_n, div_sts.done, state_r == S_DIV)
  // valid packet starts the ring read
  `PSRM_ASSERT_NEXT(a_valid_to_read, clk, rst_n, in_acc && in_data.packet_valid, state_r == S_READ)
  // invalid packet leaves sequence state alone
  `PSRM_ASSERT_NEXT(a_invalid_no_change, clk, rst_n, in_acc && !in_data.packet_valid, $stable(next_exp_r) && state_r == S_IDLE)

endmodule

/* verif/psrm_seq_rate_checker.sv */
// result checker for the packet sequence and rate monitor: predicts each report
// from the accepted packets and compares it with what the block hands out
// depends on psrm_pkg
module psrm_seq_rate_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  psrm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  psrm_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  // predicted copy of the monitor state
  logic [psrm_pkg::TIME_W-1:0] arrivals [psrm_pkg::WINDOW];
  int unsigned                 head;
  int unsigned                 fill;
  logic [psrm_pkg::SEQ_W-1:0]  want_seq;
  logic                        started;
  logic [psrm_pkg::SEQ_W-1:0]  last_missed;
  logic [psrm_pkg::SEQ_W-1:0]  last_gap_seq;
  logic [psrm_pkg::NUM_W-1:0]  last_rate;

  psrm_pkg::out_item_t reports_due [$];
  psrm_pkg::out_item_t due;
  int                  reported;

  function automatic psrm_pkg::out_item_t next_report(psrm_pkg::in_item_t pkt);
    psrm_pkg::out_item_t         rep;
    logic [psrm_pkg::TIME_W-1:0] span;
    logic [63:0]                 scaled;
    int unsigned                 oldest;
    rep.gap_flag = 1'b0;
    // the first packet only seeds the expected number
    if (started) begin
      if (pkt.seq_number != want_seq) begin
        rep.gap_flag = 1'b1;
        last_missed  = pkt.seq_number - want_seq;
        last_gap_seq = want_seq;
      end
    end else begin
      started = 1'b1;
    end
    want_seq = pkt.seq_number + 16'd1;
    arrivals[head] = pkt.arrival_ms;
    head = (head + 1) % psrm_pkg::WINDOW;
    if (fill < psrm_pkg::WINDOW) fill++;
    // rate held with fewer than two samples or a zero span
    if (fill >= 2) begin
      oldest = (head + psrm_pkg::WINDOW - fill) % psrm_pkg::WINDOW;
      span   = pkt.arrival_ms - arrivals[oldest];
      if (span != '0) begin
        scaled    = (64'(fill - 1) * 64'(psrm_pkg::RATE_SCALE)) / 64'(span);
        last_rate = scaled[psrm_pkg::NUM_W-1:0];
      end
    end
    rep.gap_size         = last_missed;
    rep.gap_expected_seq = last_gap_seq;
    rep.rx_seq_num       = pkt.seq_number;
    rep.rate_q8          = last_rate;
    return rep;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head         = 0;
      fill         = 0;
      want_seq     = '0;
      started      = 1'b0;
      last_missed  = '0;
      last_gap_seq = '0;
      last_rate    = '0;
      reports_due.delete();
      fail_count   = 0;
      reported     = 0;
      pending      = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          fail_count++;
          if (reported < REPORT_LIMIT)
            $display("%0t: unexpected report: gap=%0d missed=%h gexp=%h seq=%h rate=%0d",
                     $realtime, out_data.gap_flag, out_data.gap_size,
                     out_data.gap_expected_seq, out_data.rx_seq_num, out_data.rate_q8);
          reported++;
        end else begin
          due = reports_due.pop_front();
          if (due.gap_flag !== out_data.gap_flag ||
              due.gap_size !== out_data.gap_size ||
              due.gap_expected_seq !== out_data.gap_expected_seq ||
              due.rx_seq_num !== out_data.rx_seq_num ||
              due.rate_q8 !== out_data.rate_q8) begin
            fail_count++;
            if (reported < REPORT_LIMIT) begin
              $display("%0t: report mismatch, expected gap=%0d missed=%h gexp=%h seq=%h rate=%0d",
                       $realtime, due.gap_flag, due.gap_size, due.gap_expected_seq,
                       due.rx_seq_num, due.rate_q8);
              $display("%0t:                  actual gap=%0d missed=%h gexp=%h seq=%h rate=%0d",
                       $realtime, out_data.gap_flag, out_data.gap_size,
                       out_data.gap_expected_seq, out_data.rx_seq_num, out_data.rate_q8);
            end
            reported++;
          end
        end
      end
      if (in_valid && in_ready && in_data.packet_valid)
        reports_due.push_back(next_report(in_data));
      pending = reports_due.size();
    end
  end

endmodule

/* verif/tb_top.sv */
// top of the packet sequence and rate monitor testbench: clock, reset, packet
// stimulus, receiver back-pressure and the verdict
// depends on psrm_pkg, packet_sequence_rate_monitor and psrm_seq_rate_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS   = 285;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  psrm_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  psrm_pkg::out_item_t out_data;

  int fail_count;
  int pending;

  // idling knobs, percent of cycles
  int unsigned idle_pct;
  int unsigned stall_pct;

  // long receiver hold-off: requested by the stimulus, counted by the receiver
  int unsigned hold_requests;
  int unsigned holds_taken;
  int unsigned hold_left;

  int unsigned cycle_count;

  // running packet stream: next in-order sequence number and last arrival time
  logic [psrm_pkg::SEQ_W-1:0]  stream_seq;
  logic [psrm_pkg::TIME_W-1:0] stream_time;

  packet_sequence_rate_monitor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  psrm_seq_rate_checker watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // offer one packet from the next falling edge and hold it until taken;
  // valid is only ever rewritten at a falling edge, once per edge
  task automatic send_pkt(input logic ok, input logic [psrm_pkg::SEQ_W-1:0] seq,
                          input logic [psrm_pkg::TIME_W-1:0] ms);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{packet_valid: ok, seq_number: seq, arrival_ms: ms};
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every predicted report to come out
  task automatic drain_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // spacing between arrivals: many zero or tiny spans to push the rate high,
  // some long ones, a few that wrap the millisecond counter
  function automatic logic [psrm_pkg::TIME_W-1:0] pick_step();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15)      return '0;
    else if (roll < 45) return psrm_pkg::TIME_W'($urandom_range(3, 1));
    else if (roll < 85) return psrm_pkg::TIME_W'($urandom_range(500, 1));
    else if (roll < 97) return psrm_pkg::TIME_W'($urandom_range(100000, 1));
    else                return psrm_pkg::TIME_W'($urandom());
  endfunction

  // mostly in-order packets with random timing, plus gaps, repeats, jumps
  // and invalid noise; only valid packets count toward the total
  task automatic run_stream(input int unsigned count, input logic with_hold);
    int unsigned                sent;
    int unsigned                roll;
    logic [psrm_pkg::SEQ_W-1:0] seq;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        // noise: ignored by the block, may look like anything
        send_pkt(1'b0, psrm_pkg::SEQ_W'($urandom()), psrm_pkg::TIME_W'($urandom()));
      end else begin
        stream_time = stream_time + pick_step();
        if (roll < 78)      seq = stream_seq;
        else if (roll < 86) seq = stream_seq + psrm_pkg::SEQ_W'($urandom_range(8, 1));
        else if (roll < 90) seq = stream_seq - 16'd1;
        else if (roll < 95) seq = psrm_pkg::SEQ_W'($urandom());
        else begin
          // broken stream: restart somewhere else in both number and time
          seq         = psrm_pkg::SEQ_W'($urandom());
          stream_time = psrm_pkg::TIME_W'($urandom());
        end
        send_pkt(1'b1, seq, stream_time);
        stream_seq = seq + 16'd1;
        sent++;
        // receiver goes quiet while packets keep coming
        if (with_hold && sent == count / 3) hold_requests++;
      end
    end
  endtask

  // receiver: random stalls, or a long hold-off counted here
  initial begin
    out_ready   = 1'b0;
    holds_taken = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_requests = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: invalid before the first packet, first packet at the top of
    // both ranges, sequence wrap with a zero span, time wrap, an ignored
    // would-be gap, forward and backward gaps, then a full ring within 1 ms
    send_pkt(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
    send_pkt(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    send_pkt(1'b1, 16'h0000, 32'hFFFF_FFFF);
    send_pkt(1'b1, 16'h0001, 32'h0000_0000);
    send_pkt(1'b0, 16'h1234, 32'h0000_0005);
    send_pkt(1'b1, 16'h8000, 32'h0000_0000);
    send_pkt(1'b1, 16'h7FFF, 32'h0000_0000);
    for (int i = 0; i < 16; i++)
      send_pkt(1'b1, 16'h8000 + 16'(i), 32'h0000_0000);
    // oldest entry of the full ring at 0 ms, newest at 1 ms: top rate
    send_pkt(1'b1, 16'h8010, 32'h0000_0001);
    stream_seq  = 16'h8011;
    stream_time = 32'h0000_0001;
    drain_reports();

    // random phases with different idling on each side, draining between
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      run_stream(PHASE_ITEMS, phase == 0);
      drain_reports();
    end

    // let any stray report show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
